@@ rtl/cfow_pkg.sv @@
// shared types, constants and rounding helper for the chebyshev waveshaper
package cfow_pkg;

   localparam int SAMPLE_BITS_DEFAULT   = 16;
   localparam int FRACTION_BITS_DEFAULT = 8;

   localparam int ACC_FRAC     = 30;
   localparam int ACC_W        = 32;
   localparam int PROD_W       = 2 * ACC_W;
   localparam int RS_W         = 36;
   localparam int MAX_HARMONIC = 254;
   localparam int MAX_STEPS    = 8;
   localparam int ORDER_W      = 9;

   localparam logic signed [ACC_W-1:0]  ACC_ONE   = ACC_W'(64'sd1 <<< ACC_FRAC);
   localparam logic signed [RS_W-1:0]   RS_ONE    = RS_W'(64'sd1 <<< ACC_FRAC);
   localparam logic signed [RS_W-1:0]   RS_MONE   = -RS_ONE;
   localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(64'sd1 <<< (ACC_FRAC - 2));

   typedef struct packed {
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] t1;
      logic signed [ACC_W-1:0] t2;
      logic [MAX_STEPS-1:0]    dir;
      logic [MAX_STEPS-1:0]    act;
   } item_type;

   // round a doubled product to q.30, subtract c, saturate to [-1,1]
   function automatic logic signed [ACC_W-1:0] dbl_round_sub(
      input logic signed [PROD_W-1:0] p,
      input logic signed [ACC_W-1:0]  c
   );
      logic signed [PROD_W-1:0] s;
      logic signed [RS_W-1:0]   r;
      s = p + PROD_HALF;
      r = RS_W'(s >>> (ACC_FRAC - 1)) - RS_W'(c);
      if (r > RS_ONE) begin
         r = RS_ONE;
      end else if (r < RS_MONE) begin
         r = RS_MONE;
      end
      return ACC_W'(r);
   endfunction

endpackage

@@ rtl/cfow_prep.sv @@
// input stage: clamps, index doubling schedule and q.30 conversion
module cfow_prep #(
   parameter int SAMPLE_BITS   = cfow_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = cfow_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [SAMPLE_BITS-1:0]   in_x_sample,
   input  logic signed [FRACTION_BITS+8:0] in_harmonic,
   output logic                            out_valid,
   input  logic                            out_ready,
   output cfow_pkg::item_type              out_item,
   output logic [FRACTION_BITS-1:0]        out_frac
);

   localparam int HARM_W = FRACTION_BITS + 9;
   localparam int SFRAC  = SAMPLE_BITS - 1;
   localparam logic signed [HARM_W-1:0] H_MAX =
      $signed(HARM_W'(cfow_pkg::MAX_HARMONIC) << FRACTION_BITS);

   logic signed [cfow_pkg::ACC_W-1:0] x_conv;

   generate
      if (SFRAC <= cfow_pkg::ACC_FRAC) begin : g_widen
         assign x_conv = cfow_pkg::ACC_W'(in_x_sample) <<< (cfow_pkg::ACC_FRAC - SFRAC);
      end else begin : g_round
         logic signed [SAMPLE_BITS:0] x_sum;
         assign x_sum  = (SAMPLE_BITS + 1)'(in_x_sample) + (SAMPLE_BITS + 1)'(1);
         assign x_conv = cfow_pkg::ACC_W'(x_sum >>> (SFRAC - cfow_pkg::ACC_FRAC));
      end
   endgenerate

   logic                         valid_ff, valid_in;
   cfow_pkg::item_type           item_ff, item_in;
   logic [FRACTION_BITS-1:0]     frac_ff, frac_in;

   always_comb begin
      logic signed [HARM_W-1:0]          hc;
      logic [cfow_pkg::ORDER_W-1:0]      newo;
      logic [cfow_pkg::MAX_STEPS-1:0]    dir;
      logic [cfow_pkg::MAX_STEPS-1:0]    act;
      hc = in_harmonic;
      if (hc < 0) begin
         hc = '0;
      end else if (hc > H_MAX) begin
         hc = H_MAX;
      end
      newo = cfow_pkg::ORDER_W'(hc[FRACTION_BITS +: 8]) + cfow_pkg::ORDER_W'(2);
      dir  = '0;
      act  = '0;
      for (int j = 0; j < cfow_pkg::MAX_STEPS; j++) begin
         if (newo > cfow_pkg::ORDER_W'(2)) begin
            dir  = {dir[cfow_pkg::MAX_STEPS-2:0], newo[0]};
            act  = {act[cfow_pkg::MAX_STEPS-2:0], 1'b1};
            newo = cfow_pkg::ORDER_W'(
               ((cfow_pkg::ORDER_W + 1)'(newo) + (cfow_pkg::ORDER_W + 1)'(1)) >> 1);
         end
      end
      frac_in    = hc[FRACTION_BITS-1:0];
      item_in.x  = x_conv;
      item_in.t1 = x_conv;
      item_in.t2 = x_conv;
      item_in.dir = dir;
      item_in.act = act;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         item_ff <= item_in;
         frac_ff <= frac_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_frac  = frac_ff;

endmodule

@@ rtl/cfow_step.sv @@
// one index doubling step: multiply stage then round, subtract and saturate stage
module cfow_step #(
   parameter int FRACTION_BITS = cfow_pkg::FRACTION_BITS_DEFAULT,
   parameter int STEP          = 0,
   parameter bit FIRST         = 1'b0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  cfow_pkg::item_type       in_item,
   input  logic [FRACTION_BITS-1:0] in_frac,
   output logic                     out_valid,
   input  logic                     out_ready,
   output cfow_pkg::item_type       out_item,
   output logic [FRACTION_BITS-1:0] out_frac
);

   logic                               a_ready;
   logic                               a_valid_ff, a_valid_in;
   cfow_pkg::item_type                 a_item_ff;
   logic [FRACTION_BITS-1:0]           a_frac_ff;
   logic signed [cfow_pkg::PROD_W-1:0] a_p1_ff, a_p1_in;
   logic signed [cfow_pkg::PROD_W-1:0] a_p2_ff, a_p2_in;
   logic                               a_sel_ff, a_sel_in;
   logic                               a_act_ff;

   logic                               b_ready;
   logic                               b_valid_ff, b_valid_in;
   cfow_pkg::item_type                 b_item_ff, b_item_in;
   logic [FRACTION_BITS-1:0]           b_frac_ff;

   // operand select: T(2n)/T(2n+1) when the bit is set, T(2n+1)/T(2n+2) otherwise
   always_comb begin
      logic signed [cfow_pkg::ACC_W-1:0] op;
      a_sel_in = FIRST ? 1'b0 : in_item.dir[STEP];
      op       = a_sel_in ? in_item.t1 : in_item.t2;
      a_p1_in  = op * in_item.t1;
      a_p2_in  = op * in_item.t2;
   end

   assign a_ready    = !a_valid_ff || b_ready;
   assign a_valid_in = a_ready ? in_valid : a_valid_ff;
   assign in_ready   = a_ready;

   always_comb begin
      logic signed [cfow_pkg::ACC_W-1:0] r1;
      logic signed [cfow_pkg::ACC_W-1:0] r2;
      r1 = cfow_pkg::dbl_round_sub(a_p1_ff, a_sel_ff ? cfow_pkg::ACC_ONE : a_item_ff.x);
      r2 = cfow_pkg::dbl_round_sub(a_p2_ff, a_sel_ff ? a_item_ff.x : cfow_pkg::ACC_ONE);
      b_item_in = a_item_ff;
      if (FIRST) begin
         b_item_in.t2 = r2;
      end else if (a_act_ff) begin
         b_item_in.t1 = r1;
         b_item_in.t2 = r2;
      end
   end

   assign b_ready    = !b_valid_ff || out_ready;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_item_ff <= in_item;
         a_frac_ff <= in_frac;
         a_p1_ff   <= a_p1_in;
         a_p2_ff   <= a_p2_in;
         a_sel_ff  <= a_sel_in;
         a_act_ff  <= in_item.act[STEP];
      end
      if (b_ready) begin
         b_item_ff <= b_item_in;
         b_frac_ff <= a_frac_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;
   assign out_frac  = b_frac_ff;

endmodule

@@ rtl/cfow_interp.sv @@
// interpolation between T(k) and T(k+1), output rounding and saturation
module cfow_interp #(
   parameter int SAMPLE_BITS   = cfow_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = cfow_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  cfow_pkg::item_type            in_item,
   input  logic [FRACTION_BITS-1:0]      in_frac,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [SAMPLE_BITS-1:0] out_y_sample
);

   localparam int DW    = cfow_pkg::ACC_W + 1;
   localparam int PW    = DW + FRACTION_BITS + 1;
   localparam int YW    = 35;
   localparam int SFRAC = SAMPLE_BITS - 1;
   localparam logic signed [PW-1:0] P_HALF  = PW'(1) << (FRACTION_BITS - 1);
   localparam logic signed [YW-1:0] OUT_MAX = {{(YW - SFRAC){1'b0}}, {SFRAC{1'b1}}};
   localparam logic signed [YW-1:0] OUT_MIN = {{(YW - SFRAC){1'b1}}, {SFRAC{1'b0}}};

   logic                              a_ready;
   logic                              a_valid_ff, a_valid_in;
   logic signed [cfow_pkg::ACC_W-1:0] a_t1_ff;
   logic signed [PW-1:0]              a_p_ff, a_p_in;

   logic                              b_ready;
   logic                              b_valid_ff, b_valid_in;
   logic signed [SAMPLE_BITS-1:0]     b_y_ff, b_y_in;

   logic signed [YW-1:0]              y_sum;
   logic signed [YW-1:0]              y_scaled;

   always_comb begin
      logic signed [DW-1:0]              d;
      logic signed [FRACTION_BITS:0]     fe;
      d      = DW'(in_item.t2) - DW'(in_item.t1);
      fe     = $signed({1'b0, in_frac});
      a_p_in = PW'(d) * PW'(fe);
   end

   assign a_ready    = !a_valid_ff || b_ready;
   assign a_valid_in = a_ready ? in_valid : a_valid_ff;
   assign in_ready   = a_ready;

   always_comb begin
      logic signed [PW-1:0] ps;
      ps    = a_p_ff + P_HALF;
      y_sum = YW'(a_t1_ff) + YW'(ps >>> FRACTION_BITS);
   end

   generate
      if (SFRAC < cfow_pkg::ACC_FRAC) begin : g_down
         localparam int OSH = cfow_pkg::ACC_FRAC - SFRAC;
         localparam logic signed [YW-1:0] Y_HALF = YW'(1) << (OSH - 1);
         logic signed [YW-1:0] y_rnd;
         assign y_rnd    = y_sum + Y_HALF;
         assign y_scaled = y_rnd >>> OSH;
      end else if (SFRAC == cfow_pkg::ACC_FRAC) begin : g_same
         assign y_scaled = y_sum;
      end else begin : g_up
         assign y_scaled = y_sum <<< (SFRAC - cfow_pkg::ACC_FRAC);
      end
   endgenerate

   always_comb begin
      if (y_scaled > OUT_MAX) begin
         b_y_in = SAMPLE_BITS'(OUT_MAX);
      end else if (y_scaled < OUT_MIN) begin
         b_y_in = SAMPLE_BITS'(OUT_MIN);
      end else begin
         b_y_in = SAMPLE_BITS'(y_scaled);
      end
   end

   assign b_ready    = !b_valid_ff || out_ready;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_t1_ff <= in_item.t1;
         a_p_ff  <= a_p_in;
      end
      if (b_ready) begin
         b_y_ff <= b_y_in;
      end
   end

   assign out_valid    = b_valid_ff;
   assign out_y_sample = b_y_ff;

endmodule

@@ rtl/chebyshev_fractional_order_waveshaper.sv @@
// top level of the fractional-order chebyshev waveshaper pipeline
// Takes one sample per clock while req_stall is low and returns one result per sample,
// in order. The pipeline is the input stage, nine doubling stages (each a multiplier
// stage and a round, subtract and saturate stage; the first forms T(2) and the other
// eight step the index) and two interpolation stages. A stage whose item cannot move
// forward holds it; req_stall is high only when every stage up to the output register
// is full and rsp_stall is high. No state is kept between samples.
module chebyshev_fractional_order_waveshaper #(
   parameter int SAMPLE_BITS   = cfow_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = cfow_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [SAMPLE_BITS-1:0]   req_x_sample,
   input  logic signed [FRACTION_BITS+8:0] req_harmonic,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]   rsp_y_sample
);

   localparam int CHAIN = cfow_pkg::MAX_STEPS + 2;

   logic                     chain_valid [CHAIN];
   logic                     chain_ready [CHAIN];
   cfow_pkg::item_type       chain_item  [CHAIN];
   logic [FRACTION_BITS-1:0] chain_frac  [CHAIN];
   logic                     prep_ready;

   cfow_prep #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (prep_ready),
      .in_x_sample(req_x_sample),
      .in_harmonic(req_harmonic),
      .out_valid  (chain_valid[0]),
      .out_ready  (chain_ready[0]),
      .out_item   (chain_item[0]),
      .out_frac   (chain_frac[0])
   );

   cfow_step #(
      .FRACTION_BITS(FRACTION_BITS),
      .STEP         (0),
      .FIRST        (1'b1)
   ) u_first (
      .clock    (clock),
      .reset    (reset),
      .in_valid (chain_valid[0]),
      .in_ready (chain_ready[0]),
      .in_item  (chain_item[0]),
      .in_frac  (chain_frac[0]),
      .out_valid(chain_valid[1]),
      .out_ready(chain_ready[1]),
      .out_item (chain_item[1]),
      .out_frac (chain_frac[1])
   );

   generate
      for (genvar g = 0; g < cfow_pkg::MAX_STEPS; g++) begin : g_step
         cfow_step #(
            .FRACTION_BITS(FRACTION_BITS),
            .STEP         (g),
            .FIRST        (1'b0)
         ) u_step (
            .clock    (clock),
            .reset    (reset),
            .in_valid (chain_valid[g+1]),
            .in_ready (chain_ready[g+1]),
            .in_item  (chain_item[g+1]),
            .in_frac  (chain_frac[g+1]),
            .out_valid(chain_valid[g+2]),
            .out_ready(chain_ready[g+2]),
            .out_item (chain_item[g+2]),
            .out_frac (chain_frac[g+2])
         );
      end
   endgenerate

   cfow_interp #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_interp (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (chain_valid[CHAIN-1]),
      .in_ready    (chain_ready[CHAIN-1]),
      .in_item     (chain_item[CHAIN-1]),
      .in_frac     (chain_frac[CHAIN-1]),
      .out_valid   (rsp_valid),
      .out_ready   (!rsp_stall),
      .out_y_sample(rsp_y_sample)
   );

   assign req_stall = !prep_ready;

endmodule

@@ rtl/cfow_checker.sv @@
// port-level checks for the waveshaper and their bind to the top level
module cfow_checker #(
   parameter int SAMPLE_BITS = cfow_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_y_sample
);

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_y_sample))
      else $error("stalled result changed");

   // an empty or draining output register lets the whole pipeline move
   a_no_needless_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("request stalled while the pipeline can move");

   a_empty_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result present right after reset");

endmodule

bind chebyshev_fractional_order_waveshaper cfow_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_cfow_checker (.*);

@@ verif/testbench.sv @@
// self-checking testbench for the fractional-order chebyshev waveshaper
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS   = cfow_pkg::SAMPLE_BITS_DEFAULT;
   localparam int FRACTION_BITS = cfow_pkg::FRACTION_BITS_DEFAULT;
   localparam int ACC_FRAC      = cfow_pkg::ACC_FRAC;
   localparam int MAX_STEPS     = cfow_pkg::MAX_STEPS;
   localparam int HARM_W        = FRACTION_BITS + 9;
   localparam int TOP_HARMONIC  = cfow_pkg::MAX_HARMONIC << FRACTION_BITS;
   localparam int FRAC_MASK     = (1 << FRACTION_BITS) - 1;
   localparam int MAX_REPORTS   = 10;
   localparam int TAIL_CYCLES   = 40;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] x;
      logic signed [HARM_W-1:0]      h;
      logic signed [SAMPLE_BITS-1:0] y;
   } shaped_entry_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_x_sample;
   logic signed [HARM_W-1:0]      req_harmonic;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_BITS-1:0] rsp_y_sample;

   shaped_entry_type expected_y[$];
   int               mismatch_count;
   int               sent_count;
   int               directed_count;
   int               checked_count;
   bit               quiet;

   chebyshev_fractional_order_waveshaper #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_x_sample(req_x_sample),
      .req_harmonic(req_harmonic),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_y_sample(rsp_y_sample)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d results still outstanding", expected_y.size());
      $display("DONE: errors detected");
      $finish;
   end

   // 2*a*b rounded to q.30, minus c, held to [-1,1]
   function automatic longint twice_product_less(longint a, longint b, longint c);
      longint one;
      longint r;
      one = 64'sd1 <<< ACC_FRAC;
      r = ((a * b + (64'sd1 <<< (ACC_FRAC - 2))) >>> (ACC_FRAC - 1)) - c;
      if (r > one) begin
         r = one;
      end else if (r < -one) begin
         r = -one;
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] shaped_sample(
      logic signed [SAMPLE_BITS-1:0] xs,
      logic signed [HARM_W-1:0]      hs
   );
      longint      one;
      longint      x;
      longint      h;
      longint      frac;
      longint      t1;
      longint      t2;
      longint      a;
      longint      b;
      longint      y;
      int unsigned order;
      int unsigned dir;
      int unsigned steps;
      int          i;
      one = 64'sd1 <<< ACC_FRAC;
      x = longint'(xs) <<< (ACC_FRAC - (SAMPLE_BITS - 1));
      h = longint'(hs);
      if (h < 0) begin
         h = 0;
      end
      if (h > TOP_HARMONIC) begin
         h = TOP_HARMONIC;
      end
      frac = h & FRAC_MASK;
      order = int'(h >>> FRACTION_BITS) + 2;
      dir = 0;
      steps = 0;
      while (order > 2 && steps < MAX_STEPS) begin
         dir = (dir << 1) | (order & 1);
         steps++;
         order = (order + 1) >> 1;
      end
      t1 = x;
      t2 = twice_product_less(x, x, one);
      for (i = 0; i < steps; i++) begin
         a = t1;
         b = t2;
         if (dir & 1) begin
            t1 = twice_product_less(a, a, one);
            t2 = twice_product_less(a, b, x);
         end else begin
            t1 = twice_product_less(b, a, x);
            t2 = twice_product_less(b, b, one);
         end
         dir = dir >> 1;
      end
      y = t1 + (((t2 - t1) * frac + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS);
      y = (y + (64'sd1 <<< (ACC_FRAC - SAMPLE_BITS))) >>> (ACC_FRAC - (SAMPLE_BITS - 1));
      if (y > (64'sd1 <<< (SAMPLE_BITS - 1)) - 1) begin
         y = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
      end
      if (y < -(64'sd1 <<< (SAMPLE_BITS - 1))) begin
         y = -(64'sd1 <<< (SAMPLE_BITS - 1));
      end
      return y[SAMPLE_BITS-1:0];
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   // result side back-pressure: runs of stall and no stall
   initial begin
      int hold;
      bit level;
      hold = 0;
      level = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (quiet) begin
            level = 1'b0;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else begin
            level = ~level;
            hold = level ? pick_gap() : $urandom_range(0, 12);
            if (level && hold == 0) begin
               level = 1'b0;
            end
         end
         rsp_stall <= level;
      end
   end

   always @(negedge clock) begin
      shaped_entry_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         checked_count++;
         if (expected_y.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: unexpected result y=%0d", $realtime, rsp_y_sample);
            end
         end else begin
            want = expected_y.pop_front();
            if (rsp_y_sample !== want.y) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: x=%0d h=%0d expected y=%0d actual y=%0d", $realtime,
                     want.x, want.h, want.y, rsp_y_sample);
               end
            end
         end
      end
   end

   // one sample transfer; valid stays high on return
   task automatic send_sample(logic signed [SAMPLE_BITS-1:0] x,
                              logic signed [HARM_W-1:0] h);
      int               gap;
      bit               stalled;
      shaped_entry_type entry;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_sample <= x;
      req_harmonic <= h;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      entry.x = x;
      entry.h = h;
      entry.y = shaped_sample(x, h);
      expected_y.push_back(entry);
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_y.size() != 0);
   endtask

   function automatic logic signed [HARM_W-1:0] random_harmonic();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return HARM_W'($urandom_range(0, TOP_HARMONIC));
      end else if (r < 85) begin
         return HARM_W'(-$urandom_range(1, 1 << (HARM_W - 1)));
      end
      return HARM_W'($urandom_range(TOP_HARMONIC + 1, (1 << (HARM_W - 1)) - 1));
   endfunction

   task automatic test_corners();
      int xs[$];
      int hs[$];
      int i;
      xs = {-32768, 32767, 0, 1, -1, 16384, -16384, 23170, -32768, 32767, 12345,
            -20000, 30000, -32768, 9000, -9000, 32767, 5, -32768, 28000, 32767, -1};
      hs = {0, 0, 256, -1, -65536, 65024, 65025, 65535, 65024, 128, 384, 1856,
            32767, 32704, 64896, 511, 255, 2560, 1, 65000, 64, 768};
      for (i = 0; i < xs.size(); i++) begin
         send_sample(SAMPLE_BITS'(xs[i]), HARM_W'(hs[i]));
      end
      directed_count = xs.size();
   endtask

   task automatic test_random_mix(int count);
      repeat (count) begin
         send_sample(SAMPLE_BITS'($urandom), random_harmonic());
      end
   endtask

   task automatic test_low_orders(int count);
      logic signed [SAMPLE_BITS-1:0] x;
      repeat (count) begin
         x = ($urandom_range(0, 1) == 1) ? SAMPLE_BITS'($urandom)
             : SAMPLE_BITS'($urandom_range(0, 1) ? 32767 - $urandom_range(0, 200)
                                                 : -32768 + $urandom_range(0, 200));
         send_sample(x, HARM_W'($urandom_range(0, 2047)));
      end
   endtask

   task automatic test_drain_pause();
      test_random_mix(100);
      wait_drained();
      test_random_mix(100);
      wait_drained();
   endtask

   task automatic test_back_to_back(int count);
      quiet = 1'b1;
      test_random_mix(count);
      quiet = 1'b0;
   endtask

   initial begin
      quiet = 1'b0;
      mismatch_count = 0;
      sent_count = 0;
      checked_count = 0;
      directed_count = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_x_sample <= '0;
      req_harmonic <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_random_mix(900);
      test_drain_pause();
      test_back_to_back(300);
      test_low_orders(400);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d samples (%0d directed, clamped and in-range harmonics, full x range)",
         sent_count, directed_count);
      $display("checked %0d results with %0d mismatches", checked_count, mismatch_count);
      if (mismatch_count == 0 && expected_y.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
